### hw/rtl/vfdcbe_pkg.sv
// Shared types and constants of the display command byte encoder.
`default_nettype none

package vfdcbe_pkg;

	// Default ceiling of the digit count, and the cap of the print position
	localparam int MAX_DIGITS_DEF = 16;
	localparam logic [4:0] COUNT_CAP = 5'd16;

	// Request action codes
	localparam logic [2:0] ACT_DIGITS = 3'd0;
	localparam logic [2:0] ACT_CURSOR = 3'd1;
	localparam logic [2:0] ACT_BRIGHT = 3'd2;
	localparam logic [2:0] ACT_WRITE  = 3'd3;
	localparam logic [2:0] ACT_CLEAR  = 3'd4;
	localparam logic [2:0] ACT_PRINT  = 3'd5;
	localparam logic [2:0] ACT_EMPTY  = 3'd6;

	// Display command bytes
	localparam logic [7:0] CMD_POINTER = 8'hA0;
	localparam logic [7:0] CMD_DIGITS  = 8'hC0;
	localparam logic [7:0] CMD_BRIGHT  = 8'hE0;
	localparam logic [7:0] HOME_BYTE   = 8'hAF;
	localparam logic [7:0] SPACE_BYTE  = 8'h20;

	// Which byte the output register takes
	typedef enum logic [1:0] {
		SEL_HOME,
		SEL_BYTE,
		SEL_SPACE
	} sel_t;

	// Parts of the run that a request causes
	typedef struct packed {
		logic has_home;
		logic has_byte;
		logic has_pad;
	} plan_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic load;
		sel_t sel;
		logic last;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
		logic pad_last;
	} status_t;

endpackage

`default_nettype wire

### hw/rtl/vfdcbe_dp.sv
// Datapath: request decode, digit and print counters, pad index and output register.
`default_nettype none

module vfdcbe_dp #(
	parameter int MAX_DIGITS = vfdcbe_pkg::MAX_DIGITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [7:0]         s_tdata,   // value[7:0]
	input  wire logic [3:0]         s_tuser,   // action[2:0], first[3]
	input  wire logic               s_tlast,   // final_req
	input  wire vfdcbe_pkg::cmd_t   cmd,
	output vfdcbe_pkg::plan_t       plan,
	output vfdcbe_pkg::status_t     status,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [7:0]              m_tdata,   // command_byte[7:0]
	output logic                    m_tlast    // last
);

	localparam logic [7:0] MAX_D8 = 8'(MAX_DIGITS);
	localparam logic [4:0] MAX_D  = 5'(MAX_DIGITS);

	logic [2:0] action;
	logic       first;
	logic [8:0] mapped;
	logic [4:0] digits_v;
	logic [3:0] cursor_v;
	logic [3:0] cursor_code;
	logic [4:0] bright_v;
	logic [4:0] pc_base;
	logic [7:0] byte_d;
	logic [4:0] dc_d;
	logic [4:0] pc_d;
	logic [4:0] pad_d;

	logic [7:0] byte_q;
	logic [4:0] pad_idx_q;
	logic [4:0] dc_q;
	logic [4:0] pc_q;
	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic       m_tlast_q;

	// Map a character code to a display code; bit 8 marks a code that maps
	function automatic logic [8:0] map_char(input logic [7:0] c);
		logic [8:0] r;
		r = '0;
		if (c >= 8'd64 && c <= 8'd95) begin
			r = {1'b1, c - 8'd64};
		end else if (c >= 8'd32 && c <= 8'd63) begin
			r = {1'b1, c};
		end else if (c >= 8'd97 && c <= 8'd122) begin
			r = {1'b1, c - 8'd96};
		end
		return r;
	endfunction

	assign action = s_tuser[2:0];
	assign first  = s_tuser[3];
	assign mapped = map_char(s_tdata);

	// Clamp the numeric arguments
	assign digits_v    = (s_tdata > MAX_D8) ? MAX_D : s_tdata[4:0];
	assign cursor_v    = (s_tdata > 8'd15) ? 4'hF : s_tdata[3:0];
	assign cursor_code = (cursor_v == 4'd0) ? 4'hF : cursor_v - 4'd1;
	assign bright_v    = (s_tdata > 8'd31) ? 5'h1F : s_tdata[4:0];
	assign pc_base     = first ? 5'd0 : pc_q;

	// Decode the request into its run and next counter values
	always_comb begin
		plan   = '0;
		byte_d = s_tdata;
		dc_d   = dc_q;
		pc_d   = pc_q;
		pad_d  = 5'd0;
		case (action)
			vfdcbe_pkg::ACT_DIGITS: begin
				dc_d          = digits_v;
				byte_d        = vfdcbe_pkg::CMD_DIGITS | {4'b0, digits_v[3:0]};
				plan.has_byte = 1'b1;
			end
			vfdcbe_pkg::ACT_CURSOR: begin
				byte_d        = vfdcbe_pkg::CMD_POINTER | {4'b0, cursor_code};
				plan.has_byte = 1'b1;
			end
			vfdcbe_pkg::ACT_BRIGHT: begin
				byte_d        = vfdcbe_pkg::CMD_BRIGHT | {3'b0, bright_v};
				plan.has_byte = 1'b1;
			end
			vfdcbe_pkg::ACT_WRITE: begin
				byte_d        = mapped[7:0];
				plan.has_byte = mapped[8];
			end
			vfdcbe_pkg::ACT_CLEAR: begin
				plan.has_home = 1'b1;
				plan.has_pad  = (dc_q != 5'd0);
			end
			vfdcbe_pkg::ACT_PRINT: begin
				plan.has_home = first;
				byte_d        = mapped[7:0];
				plan.has_byte = mapped[8];
				pc_d          = (pc_base < vfdcbe_pkg::COUNT_CAP) ? pc_base + 5'd1 : pc_base;
				pad_d         = pc_d;
				plan.has_pad  = s_tlast && (pc_d < dc_q);
			end
			vfdcbe_pkg::ACT_EMPTY: begin
				pc_d          = 5'd0;
				plan.has_home = 1'b1;
				plan.has_pad  = (dc_q != 5'd0);
			end
			default: begin
			end
		endcase
	end

	// Hold the request results and advance the pad index per space sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_q <= 5'd0;
			pc_q <= 5'd0;
		end else if (cmd.accept) begin
			dc_q <= dc_d;
			pc_q <= pc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q    <= byte_d;
			pad_idx_q <= pad_d;
		end else if (cmd.load && cmd.sel == vfdcbe_pkg::SEL_SPACE) begin
			pad_idx_q <= pad_idx_q + 5'd1;
		end
	end

	// Output register: load a byte, drop valid once the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_tlast_q <= cmd.last;
			unique case (cmd.sel)
				vfdcbe_pkg::SEL_HOME:  m_tdata_q <= vfdcbe_pkg::HOME_BYTE;
				vfdcbe_pkg::SEL_BYTE:  m_tdata_q <= byte_q;
				vfdcbe_pkg::SEL_SPACE: m_tdata_q <= vfdcbe_pkg::SPACE_BYTE;
				default:               m_tdata_q <= vfdcbe_pkg::SPACE_BYTE;
			endcase
		end
	end

	assign status.out_free = !m_tvalid_q || m_tready;
	assign status.pad_last = ({1'b0, pad_idx_q} + 6'd1) >= {1'b0, dc_q};

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

`default_nettype wire

### hw/rtl/vfdcbe_ctrl.sv
// Controller: sequences home, data byte and padding spaces of one request.
`default_nettype none

module vfdcbe_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire vfdcbe_pkg::plan_t   plan,
	input  wire vfdcbe_pkg::status_t status,
	output vfdcbe_pkg::cmd_t         cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   home_q;
	logic   byte_q;
	logic   pad_q;

	assign s_tready = (state_q == ST_IDLE);

	// Pick the next byte of the run whenever the output register frees up
	always_comb begin
		cmd        = '0;
		cmd.accept = s_tvalid && s_tready;
		if (state_q == ST_EMIT && status.out_free) begin
			cmd.load = 1'b1;
			priority if (home_q) begin
				cmd.sel  = vfdcbe_pkg::SEL_HOME;
				cmd.last = !byte_q && !pad_q;
			end else if (byte_q) begin
				cmd.sel  = vfdcbe_pkg::SEL_BYTE;
				cmd.last = !pad_q;
			end else begin
				cmd.sel  = vfdcbe_pkg::SEL_SPACE;
				cmd.last = status.pad_last;
			end
		end
	end

	// Hold state and the pending parts of the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			home_q  <= 1'b0;
			byte_q  <= 1'b0;
			pad_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.accept) begin
						home_q <= plan.has_home;
						byte_q <= plan.has_byte;
						pad_q  <= plan.has_pad;
						if (plan.has_home || plan.has_byte || plan.has_pad) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (cmd.load) begin
						priority if (home_q) begin
							home_q <= 1'b0;
						end else if (byte_q) begin
							byte_q <= 1'b0;
						end else begin
							if (status.pad_last) begin
								pad_q <= 1'b0;
							end
						end
						if (cmd.last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/vfd_command_byte_encoder_unit.sv
// Top level of the display command byte encoder.
//
// Takes one display request per input transaction (set digit count, set cursor,
// brightness, write character, clear, print character, empty print) and sends
// the display command bytes it causes as a run of output transactions, the
// final byte of each run marked by m_tlast. A request that causes no byte
// (unmapped character, unused action code) produces no output. The block
// takes one request at a time: a request is accepted and then the sequencer
// loads one byte per cycle into the output register while the output side
// does not stall, and it takes no new request until the run is loaded;
// s_tready returns as soon as the last byte is in the output register, while
// that byte may still wait to be taken. The digit count and the print
// position reset to zero; there is no clearing pass.
`default_nettype none

module vfd_command_byte_encoder_unit #(
	parameter int MAX_DIGITS = vfdcbe_pkg::MAX_DIGITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // value[7:0]
	input  wire logic [3:0] s_tuser,   // action[2:0], first[3]
	input  wire logic       s_tlast,   // final_req
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // command_byte[7:0]
	output logic            m_tlast    // last
);

	vfdcbe_pkg::cmd_t    cmd;
	vfdcbe_pkg::plan_t   plan;
	vfdcbe_pkg::status_t status;

	vfdcbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.plan     (plan),
		.status   (status),
		.cmd      (cmd)
	);

	vfdcbe_dp #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.cmd      (cmd),
		.plan     (plan),
		.status   (status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

### hw/rtl/vfdcbe_checker.sv
// Port-level checker of the display command byte encoder, bound to the top level.
`default_nettype none

module vfdcbe_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic [7:0] s_tdata,
	input wire logic [3:0] s_tuser,
	input wire logic       s_tlast,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tlast
);

	// Hold a stalled output transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output transaction changed");

	// No new request while a run is still being sent
	a_busy_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready in the middle of a run");

	// A run continues back to back once a non-final byte is taken
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside a run");

	// A set digit count request always produces a byte, so input stalls
	a_digits_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[2:0] == vfdcbe_pkg::ACT_DIGITS |=> !s_tready)
		else $error("set digit count request produced no run");

endmodule

bind vfd_command_byte_encoder_unit vfdcbe_checker u_chk (.*);

`default_nettype wire

### bench/tb_vfd_command_byte_encoder_unit.sv
// Self-checking bench for the display command byte encoder: random requests, byte-level check.
`default_nettype none

module tb_vfd_command_byte_encoder_unit;
	import vfdcbe_pkg::*;

	localparam logic [2:0] ACT_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_REQUESTS = 400;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;

	// One display byte with its end-of-run mark
	typedef struct packed {
		logic [7:0] cmd_byte;
		logic       last_flag;
	} disp_byte_t;

	// Tracks digit count and print position, holds the bytes still to come
	class vfd_byte_scoreboard;
		disp_byte_t pending_bytes[$];
		logic [7:0] run_bytes[$];
		logic [4:0] digits_used;
		logic [4:0] print_pos;
		int         mismatches;

		function new();
			digits_used = '0;
			print_pos = '0;
			mismatches = 0;
		endfunction

		task report(input string msg);
			if (mismatches < 100) begin
				$display("ERROR at %0t: %s", $time, msg);
			end
			mismatches++;
		endtask

		// Queue the display code of a character, if it has one
		function void add_char(input logic [7:0] c);
			if (c >= 8'd64 && c <= 8'd95) begin
				run_bytes.push_back(c - 8'd64);
			end else if (c >= 8'd32 && c <= 8'd63) begin
				run_bytes.push_back(c);
			end else if (c >= 8'd97 && c <= 8'd122) begin
				run_bytes.push_back(c - 8'd96);
			end
		endfunction

		// Fill with spaces from a position up to the digit count
		function void add_spaces(input int from_pos);
			int i;
			for (i = from_pos; i < digits_used && i < COUNT_CAP; i++) begin
				run_bytes.push_back(SPACE_BYTE);
			end
		endfunction

		// Work out the bytes of one accepted request
		function void note_request(input logic [2:0] action, input logic [7:0] value,
				input logic first, input logic fin);
			logic [7:0] code;
			int i;
			run_bytes.delete();
			case (action)
				ACT_DIGITS: begin
					code = (value > 8'd16) ? 8'd16 : value;
					digits_used = code[4:0];
					run_bytes.push_back(CMD_DIGITS | {4'b0, code[3:0]});
				end
				ACT_CURSOR: begin
					code = (value > 8'd15) ? 8'd15 : value;
					code = (code == 8'd0) ? 8'd15 : code - 8'd1;
					run_bytes.push_back(CMD_POINTER | {4'b0, code[3:0]});
				end
				ACT_BRIGHT: begin
					code = (value > 8'd31) ? 8'd31 : value;
					run_bytes.push_back(CMD_BRIGHT | {3'b0, code[4:0]});
				end
				ACT_WRITE: begin
					add_char(value);
				end
				ACT_CLEAR: begin
					run_bytes.push_back(HOME_BYTE);
					add_spaces(0);
				end
				ACT_PRINT: begin
					if (first) begin
						run_bytes.push_back(HOME_BYTE);
						print_pos = '0;
					end
					add_char(value);
					if (print_pos < COUNT_CAP) begin
						print_pos = print_pos + 5'd1;
					end
					if (fin) begin
						add_spaces(int'(print_pos));
					end
				end
				ACT_EMPTY: begin
					print_pos = '0;
					run_bytes.push_back(HOME_BYTE);
					add_spaces(0);
				end
				default: begin
				end
			endcase
			for (i = 0; i < run_bytes.size(); i++) begin
				pending_bytes.push_back('{cmd_byte: run_bytes[i],
					last_flag: (i == run_bytes.size() - 1)});
			end
		endfunction

		// Compare one output transaction with the oldest expected byte
		task check_byte(input logic [7:0] data, input logic last);
			disp_byte_t want;
			if (pending_bytes.size() == 0) begin
				report($sformatf("unexpected byte %02h last=%0b", data, last));
			end else begin
				want = pending_bytes.pop_front();
				if (data !== want.cmd_byte) begin
					report($sformatf("command byte %02h, want %02h", data, want.cmd_byte));
				end
				if (last !== want.last_flag) begin
					report($sformatf("last %0b, want %0b (byte %02h)", last, want.last_flag,
						want.cmd_byte));
				end
			end
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic [3:0] s_tuser;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tlast;

	vfd_byte_scoreboard byte_sb;
	bit idle_en = 1'b1;
	bit hold_done = 1'b0;
	int requests_taken = 0;
	int cycle_count = 0;

	vfd_command_byte_encoder_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Check every output transaction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			byte_sb.check_byte(m_tdata, m_tlast);
		end
	end

	// Receiver: random stalls, one long hold-off once traffic is going
	initial begin
		int k;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && requests_taken >= 100) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				for (k = 0; k < HOLD_CYCLES; k++) begin
					@(negedge clk);
				end
			end
			m_tready <= !(idle_en && $urandom_range(99) < 12);
		end
	end

	// Offer one request and hold it until the transaction completes
	task automatic send_request(input logic [2:0] action, input logic [7:0] value,
			input logic first, input logic fin);
		while (idle_en && $urandom_range(99) < 12) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		s_tuser <= {first, action};
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
		byte_sb.note_request(action, value, first, fin);
		requests_taken++;
		@(negedge clk);
	endtask

	// Pick a character, mostly from the mapped ranges
	function automatic logic [7:0] pick_char();
		return ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(32, 122));
	endfunction

	// Send a print string; an empty one goes as an empty print
	task automatic send_print_string(input int len, input bit from_home);
		int i;
		if (len == 0) begin
			send_request(ACT_EMPTY, 8'($urandom_range(255)), 1'($urandom_range(1)),
				1'($urandom_range(1)));
		end else begin
			for (i = 0; i < len; i++) begin
				send_request(ACT_PRINT, pick_char(), from_home && (i == 0), i == len - 1);
			end
		end
	endtask

	// Reset, directed requests, then random traffic and drain
	initial begin
		int sent;
		int pick;
		int len;
		byte_sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Clamps and command extremes
		send_request(ACT_CLEAR, 8'd0, 1'b0, 1'b0);
		send_request(ACT_DIGITS, 8'd255, 1'b1, 1'b1);
		send_request(ACT_DIGITS, 8'd0, 1'b0, 1'b0);
		send_request(ACT_CURSOR, 8'd0, 1'b0, 1'b0);
		send_request(ACT_CURSOR, 8'd1, 1'b0, 1'b0);
		send_request(ACT_CURSOR, 8'd255, 1'b0, 1'b0);
		send_request(ACT_BRIGHT, 8'd0, 1'b0, 1'b0);
		send_request(ACT_BRIGHT, 8'd255, 1'b0, 1'b0);
		// Character range edges, unmapped ones send nothing
		send_request(ACT_WRITE, 8'd31, 1'b0, 1'b0);
		send_request(ACT_WRITE, 8'd32, 1'b0, 1'b0);
		send_request(ACT_WRITE, 8'd95, 1'b0, 1'b0);
		send_request(ACT_WRITE, 8'd96, 1'b0, 1'b0);
		send_request(ACT_WRITE, 8'd97, 1'b0, 1'b0);
		send_request(ACT_WRITE, 8'd122, 1'b0, 1'b0);
		send_request(ACT_WRITE, 8'd123, 1'b0, 1'b0);
		// Unused action code
		send_request(ACT_UNUSED, 8'd65, 1'b1, 1'b1);
		// Full clear and the longest print run
		send_request(ACT_DIGITS, 8'd16, 1'b0, 1'b0);
		send_request(ACT_CLEAR, 8'd0, 1'b0, 1'b0);
		send_request(ACT_PRINT, 8'd65, 1'b1, 1'b1);
		send_request(ACT_PRINT, 8'd0, 1'b1, 1'b1);
		// Short print, continued print without home, empty print
		send_request(ACT_DIGITS, 8'd5, 1'b0, 1'b0);
		send_request(ACT_PRINT, 8'd64, 1'b1, 1'b0);
		send_request(ACT_PRINT, 8'd63, 1'b0, 1'b1);
		send_request(ACT_PRINT, 8'd200, 1'b0, 1'b1);
		send_request(ACT_EMPTY, 8'd0, 1'b0, 1'b0);

		// Random traffic, mostly well-formed print strings
		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			idle_en = !(sent >= 150 && sent < 250);
			pick = $urandom_range(99);
			if (pick < 10) begin
				send_request(ACT_DIGITS, ($urandom_range(4) == 0) ? 8'($urandom_range(255)) :
					8'($urandom_range(16)), 1'($urandom_range(1)), 1'($urandom_range(1)));
				sent++;
			end else if (pick < 58) begin
				len = ($urandom_range(5) == 0) ? $urandom_range(16, 20) : $urandom_range(0, 8);
				send_print_string(len, pick >= 15);
				sent += (len == 0) ? 1 : len;
			end else if (pick < 65) begin
				send_request(ACT_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
				sent++;
			end else if (pick < 72) begin
				send_request(ACT_CURSOR, 8'($urandom_range(255)), 1'b0, 1'b0);
				sent++;
			end else if (pick < 79) begin
				send_request(ACT_BRIGHT, 8'($urandom_range(255)), 1'b0, 1'b0);
				sent++;
			end else if (pick < 88) begin
				send_request(ACT_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
				sent++;
			end else begin
				send_request(3'($urandom_range(7)), 8'($urandom_range(255)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
				sent++;
			end
		end
		idle_en = 1'b1;
		s_tvalid <= 1'b0;

		// Drain, then allow stray bytes to show up
		while (byte_sb.pending_bytes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (byte_sb.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

`default_nettype wire
